// ===== design/captive_dns_reply_builder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the captive DNS reply builder
// Clocked concurrent checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef CAPTIVE_DNS_REPLY_BUILDER_MACROS_SVH
`define CAPTIVE_DNS_REPLY_BUILDER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle check: prop must hold at every edge out of reset
`define CDNS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// next-cycle check: cond at one edge implies res at the next
`define CDNS_ASSERT_NEXT(lbl, clk, rstn, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (res)) \
        else $error("assertion failed");
`else
`define CDNS_ASSERT(lbl, clk, rstn, prop)
`define CDNS_ASSERT_NEXT(lbl, clk, rstn, cond, res)
`endif

`endif

// ===== design/cdns_pkg.sv =====
// ----------------------------------------------------------------------------
// cdns_pkg
// Shared constants, types and the reply byte table of the DNS reply builder.
// ----------------------------------------------------------------------------
package cdns_pkg;

    localparam int MAX_PACKET   = 512;
    localparam int NAME_START   = 12;
    localparam int ANSWER_BYTES = 16;
    localparam int HDR_WRITES   = 8;
    localparam int REPLY_LIMIT  = 512;
    localparam int TTL_SECONDS  = 60;

    localparam int POS_W  = $clog2(MAX_PACKET + 1);
    localparam int PW     = POS_W + 1;
    localparam int LBL_W  = $clog2(MAX_PACKET + 256 + 1);
    localparam int OFF_W  = 9;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 10;
    localparam int ST_W   = 3;
    localparam int ADDR_W = 32;
    localparam int ITEMS_MAX = HDR_WRITES + ANSWER_BYTES + 1;
    localparam int IDX_W  = $clog2(ITEMS_MAX);
    localparam int ANS_W  = $clog2(ANSWER_BYTES);
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    localparam logic [ADDR_W-1:0] ADDR_RESET = 32'hC0A8_0401;

    typedef enum logic [ST_W-1:0] {
        ST_ANSWERED  = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_SHORT     = 3'd2,
        ST_QCOUNT    = 3'd3,
        ST_MALFORMED = 3'd4,
        ST_TOO_LONG  = 3'd5
    } status_t;

    // summary of one finished query, handed from the parser to the sequencer
    typedef struct packed {
        logic [POS_W-1:0] len;
        logic             qt_one;
        logic             end_seen;
        logic [POS_W-1:0] end_pos;
        logic             kind_a;
    } run_desc_t;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [BYTE_W-1:0] value;
    } wr_item_t;

    // write number idx of a passing run: header patches, then the answer record
    function automatic wr_item_t reply_item(logic [IDX_W-1:0]  idx,
                                            logic              is_a,
                                            logic [PW-1:0]     p,
                                            logic [ADDR_W-1:0] addr);
        wr_item_t         it;
        logic [ANS_W-1:0] k;
        logic [IDX_W-1:0] rel;
        rel = idx - IDX_W'(HDR_WRITES);
        k   = rel[ANS_W-1:0];
        it  = '0;
        if (idx < IDX_W'(HDR_WRITES))
        begin
            unique case (idx[2:0])
                3'd0: it = '{offset: OFF_W'(2),  value: 8'h81};
                3'd1: it = '{offset: OFF_W'(3),  value: 8'h80};
                3'd2: it = '{offset: OFF_W'(8),  value: 8'h00};
                3'd3: it = '{offset: OFF_W'(9),  value: 8'h00};
                3'd4: it = '{offset: OFF_W'(10), value: 8'h00};
                3'd5: it = '{offset: OFF_W'(11), value: 8'h00};
                3'd6: it = '{offset: OFF_W'(6),  value: 8'h00};
                3'd7: it = '{offset: OFF_W'(7),  value: {7'd0, is_a}};
                default: it = '0;
            endcase
        end
        else
        begin
            it.offset = p[OFF_W-1:0] + OFF_W'(k);
            unique case (k)
                4'd0:  it.value = 8'hC0;
                4'd1:  it.value = 8'h0C;
                4'd3:  it.value = 8'h01;
                4'd5:  it.value = 8'h01;
                4'd9:  it.value = BYTE_W'(TTL_SECONDS);
                4'd11: it.value = 8'h04;
                4'd12: it.value = addr[31:24];
                4'd13: it.value = addr[23:16];
                4'd14: it.value = addr[15:8];
                4'd15: it.value = addr[7:0];
                default: it.value = 8'h00;
            endcase
        end
        return it;
    endfunction

endpackage

// ===== design/captive_dns_reply_builder.sv =====
// ----------------------------------------------------------------------------
// captive_dns_reply_builder
// Turns a streamed DNS query into in-place reply patches plus an A answer.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  -------  ---  ---------------------------------------------------------
//  s_*      in   one query byte; tlast on the final byte
//  m_*      out  one buffer write, or the finish beat (tlast) with length/status
//  cfg_*    in   answer_address (IPv4, first octet in bits 31:24)
//
//  - One query byte per cycle; the walk does a single compare/add per byte.
//  - A packet end yields a run of 1 (rejected), 9 (empty reply) or 25 (A answer)
//    result beats, issued one per cycle by the sequencer; the last byte passes
//    the run descriptor, the busy flag and the output register before the first beat.
//  - Input keeps flowing during a run; it stalls only when a second packet end
//    is held while the sequencer is still busy with the previous run.
//  - Output stalls hold the result register; the sequencer waits with it.
//  - rst_n is asynchronous; answer_address resets to 0xC0A80401.
// ----------------------------------------------------------------------------
module captive_dns_reply_builder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cdns_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,   // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [8:0] write_offset, [16:9] write_value, [26:17] reply_length,
    // [29:27] status, [31:30] zero
    output logic [cdns_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,   // finish
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cdns_pkg::ADDR_W-1:0]         cfg_data   // answer_address
);

    logic [cdns_pkg::ADDR_W-1:0] answer_address_reg;
    logic                        desc_valid;
    logic                        desc_take;
    cdns_pkg::run_desc_t         desc;

    // config is to be written only while idle (a rule on the user), so the sequencer reads it live
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            answer_address_reg <= cdns_pkg::ADDR_RESET;
        else if (cfg_valid && cfg_ready)
            answer_address_reg <= cfg_data;
    end

    // byte walker: updates parse state each beat, snapshots a run summary on tlast
    cdns_walk u_walk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_take  (desc_take)
    );

    // checker + write sequencer: status on load, then one result beat per cycle unless the output stalls
    cdns_seq u_seq
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .desc_valid     (desc_valid),
        .desc           (desc),
        .desc_take      (desc_take),
        .answer_address (answer_address_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

endmodule

// ===== design/cdns_walk.sv =====
// ----------------------------------------------------------------------------
// cdns_walk
// Per-byte query parser: question count, label walk, query type capture.
// ----------------------------------------------------------------------------
`include "captive_dns_reply_builder_macros.svh"

module cdns_walk
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cdns_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,   // last_byte
    output logic                                desc_valid,
    output cdns_pkg::run_desc_t                 desc,
    input  logic                                desc_take
);

    localparam int POS_W = cdns_pkg::POS_W;
    localparam int PW    = cdns_pkg::PW;
    localparam int LBL_W = cdns_pkg::LBL_W;

    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [15:0]      qtotal_reg, qtotal_next;
    logic [LBL_W-1:0] label_pos_reg, label_pos_next;
    logic [POS_W-1:0] end_pos_reg, end_pos_next;
    logic             end_seen_reg, end_seen_next;
    logic [15:0]      kind_reg, kind_next;
    logic             desc_valid_reg;
    cdns_pkg::run_desc_t desc_reg;

    logic             accept;
    logic             in_range;
    logic [7:0]       db;
    logic [PW-1:0]    pos_x;
    logic [PW-1:0]    end1;
    logic [PW-1:0]    end2;

    assign s_tready   = !desc_valid_reg || desc_take;
    assign accept     = s_tvalid && s_tready;
    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;
    assign db         = s_tdata[7:0];
    assign in_range   = byte_pos_reg < POS_W'(cdns_pkg::MAX_PACKET);
    assign pos_x      = PW'(byte_pos_reg);
    assign end1       = PW'(end_pos_reg) + PW'(1);
    assign end2       = PW'(end_pos_reg) + PW'(2);

    always_comb
    begin
        byte_pos_next  = byte_pos_reg;
        qtotal_next    = qtotal_reg;
        label_pos_next = label_pos_reg;
        end_pos_next   = end_pos_reg;
        end_seen_next  = end_seen_reg;
        kind_next      = kind_reg;
        if (in_range)
        begin
            if (byte_pos_reg == POS_W'(4))
                qtotal_next[15:8] = db;
            else if (byte_pos_reg == POS_W'(5))
                qtotal_next[7:0] = db;
            if (end_seen_reg)
            begin
                if (pos_x == end1)
                    kind_next[15:8] = db;
                else if (pos_x == end2)
                    kind_next[7:0] = db;
            end
            else if (LBL_W'(byte_pos_reg) == label_pos_reg)
            begin
                if (db == 8'd0)
                begin
                    end_pos_next  = byte_pos_reg;
                    end_seen_next = 1'b1;
                end
                else
                    label_pos_next = LBL_W'(byte_pos_reg) + LBL_W'(db) + LBL_W'(1);
            end
            byte_pos_next = byte_pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= '0;
            qtotal_reg     <= '0;
            label_pos_reg  <= LBL_W'(cdns_pkg::NAME_START);
            end_pos_reg    <= '0;
            end_seen_reg   <= 1'b0;
            kind_reg       <= '0;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && s_tlast)
            begin
                // packet done: walk restarts for the next query
                byte_pos_reg   <= '0;
                qtotal_reg     <= '0;
                label_pos_reg  <= LBL_W'(cdns_pkg::NAME_START);
                end_pos_reg    <= '0;
                end_seen_reg   <= 1'b0;
                kind_reg       <= '0;
                desc_valid_reg <= 1'b1;
            end
            else
            begin
                if (accept)
                begin
                    byte_pos_reg  <= byte_pos_next;
                    qtotal_reg    <= qtotal_next;
                    label_pos_reg <= label_pos_next;
                    end_pos_reg   <= end_pos_next;
                    end_seen_reg  <= end_seen_next;
                    kind_reg      <= kind_next;
                end
                if (desc_take)
                    desc_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tlast)
        begin
            desc_reg.len      <= byte_pos_next;
            desc_reg.qt_one   <= (qtotal_next == 16'd1);
            desc_reg.end_seen <= end_seen_next;
            desc_reg.end_pos  <= end_pos_next;
            desc_reg.kind_a   <= (kind_next == 16'd1);
        end
    end

    `CDNS_ASSERT(a_pos_bound, clk, rst_n, byte_pos_reg <= POS_W'(cdns_pkg::MAX_PACKET))
    `CDNS_ASSERT_NEXT(a_desc_hold, clk, rst_n, desc_valid_reg && !desc_take, desc_valid_reg && $stable(desc_reg))

endmodule

// ===== design/cdns_seq.sv =====
// ----------------------------------------------------------------------------
// cdns_seq
// Run checker and reply write sequencer with the registered output stage.
// ----------------------------------------------------------------------------
`include "captive_dns_reply_builder_macros.svh"

module cdns_seq
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                desc_valid,
    input  cdns_pkg::run_desc_t                 desc,
    output logic                                desc_take,
    input  logic [cdns_pkg::ADDR_W-1:0]         answer_address,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cdns_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    localparam int PW    = cdns_pkg::PW;
    localparam int IDX_W = cdns_pkg::IDX_W;
    localparam int OFF_W = cdns_pkg::OFF_W;
    localparam int BYTE_W = cdns_pkg::BYTE_W;
    localparam int LEN_W = cdns_pkg::LEN_W;
    localparam int FIELD_W = OFF_W + BYTE_W + LEN_W + cdns_pkg::ST_W;

    logic                 busy_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     last_idx_reg;
    logic                 is_a_reg;
    logic [PW-1:0]        p_reg;
    cdns_pkg::status_t    status_reg;
    logic [LEN_W-1:0]     rlen_reg;

    logic                 out_valid_reg;
    logic                 out_last_reg;
    logic [OFF_W-1:0]     out_off_reg;
    logic [BYTE_W-1:0]    out_val_reg;
    logic [LEN_W-1:0]     out_len_reg;
    cdns_pkg::status_t    out_st_reg;

    // load-time checks
    logic [PW-1:0]        len_x, end4, p_w, p_ans;
    cdns_pkg::status_t    st_chk;
    logic [IDX_W-1:0]     last_chk;
    logic [LEN_W-1:0]     rlen_chk;
    logic                 load, advance, emit, fin;
    cdns_pkg::wr_item_t   item;

    assign desc_take = !busy_reg;
    assign load      = desc_valid && !busy_reg;
    assign advance   = !out_valid_reg || m_tready;
    assign emit      = busy_reg && advance;
    assign fin       = (idx_reg == last_idx_reg);

    assign len_x = PW'(desc.len);
    assign end4  = PW'(desc.end_pos) + PW'(4);
    assign p_w   = PW'(desc.end_pos) + PW'(5);
    assign p_ans = p_w + PW'(cdns_pkg::ANSWER_BYTES);

    always_comb
    begin
        rlen_chk = '0;
        last_chk = '0;
        priority if (len_x < PW'(cdns_pkg::NAME_START))
            st_chk = cdns_pkg::ST_SHORT;
        else if (!desc.qt_one)
            st_chk = cdns_pkg::ST_QCOUNT;
        else if (!desc.end_seen || end4 >= len_x)
            st_chk = cdns_pkg::ST_MALFORMED;
        else if (desc.kind_a ? (p_ans > PW'(cdns_pkg::REPLY_LIMIT))
                             : (p_w > PW'(cdns_pkg::REPLY_LIMIT)))
            st_chk = cdns_pkg::ST_TOO_LONG;
        else if (desc.kind_a)
        begin
            st_chk   = cdns_pkg::ST_ANSWERED;
            rlen_chk = p_ans[LEN_W-1:0];
            last_chk = IDX_W'(cdns_pkg::HDR_WRITES + cdns_pkg::ANSWER_BYTES);
        end
        else
        begin
            st_chk   = cdns_pkg::ST_EMPTY;
            rlen_chk = p_w[LEN_W-1:0];
            last_chk = IDX_W'(cdns_pkg::HDR_WRITES);
        end
    end

    assign item = cdns_pkg::reply_item(idx_reg, is_a_reg, p_reg, answer_address);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (emit)
            begin
                if (fin)
                    busy_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + IDX_W'(1);
            end
            if (advance)
                out_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_idx_reg <= last_chk;
            is_a_reg     <= desc.kind_a;
            p_reg        <= p_w;
            status_reg   <= st_chk;
            rlen_reg     <= rlen_chk;
        end
        if (emit)
        begin
            out_last_reg <= fin;
            out_off_reg  <= fin ? '0 : item.offset;
            out_val_reg  <= fin ? '0 : item.value;
            out_len_reg  <= fin ? rlen_reg : '0;
            out_st_reg   <= fin ? status_reg : cdns_pkg::ST_ANSWERED;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(cdns_pkg::M_TDATA_W - FIELD_W){1'b0}},
                       out_st_reg, out_len_reg, out_val_reg, out_off_reg};

    `CDNS_ASSERT(a_idx_range, clk, rst_n, !busy_reg || idx_reg <= last_idx_reg)
    `CDNS_ASSERT(a_write_clean, clk, rst_n, !(out_valid_reg && !out_last_reg) || (out_len_reg == '0 && out_st_reg == cdns_pkg::ST_ANSWERED))
    `CDNS_ASSERT(a_fail_no_len, clk, rst_n, !(out_valid_reg && out_last_reg && out_st_reg != cdns_pkg::ST_ANSWERED && out_st_reg != cdns_pkg::ST_EMPTY) || out_len_reg == '0)

endmodule
